### design/mbg_pkg.sv
// shared types, constants and helper functions of the maze backtracker generator
`default_nettype none

package mbg_pkg;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int CELL_W = ROW_W + COL_W;
  localparam int CELLS  = 1 << CELL_W;
  localparam int CNT_W  = CELL_W + 1;
  localparam int MAX_ROWS = 1 << ROW_W;
  localparam int MAX_COLS = 1 << COL_W;
  localparam int DIM_W  = 6;
  localparam int FUNC_W = 2;
  localparam int DRAW_W = 2;
  localparam int EV_W   = 3;
  localparam int DIR_W  = 2;
  localparam int WALL_W = 4;
  localparam int NB_W   = 3;
  localparam int MAP_W  = WALL_W + 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);

  localparam logic [FUNC_W-1:0] FN_START = 2'd0;
  localparam logic [FUNC_W-1:0] FN_STEP  = 2'd1;

  localparam logic [EV_W-1:0] EV_CARVED = 3'd0;
  localparam logic [EV_W-1:0] EV_BACK   = 3'd1;
  localparam logic [EV_W-1:0] EV_IDLE   = 3'd2;
  localparam logic [EV_W-1:0] EV_START  = 3'd3;
  localparam logic [EV_W-1:0] EV_READ   = 3'd4;

  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  localparam logic [WALL_W-1:0] WALLS_ALL  = 4'hf;
  localparam logic [WALL_W-1:0] WALL_LEFT  = 4'h1;
  localparam logic [WALL_W-1:0] WALL_RIGHT = 4'h2;
  localparam logic [WALL_W-1:0] WALL_UP    = 4'h4;
  localparam logic [WALL_W-1:0] WALL_DOWN  = 4'h8;

  localparam logic [NB_W-1:0] NB_OWN  = 3'd0;
  localparam logic [NB_W-1:0] NB_LAST = 3'd4;

  localparam logic [0:0] CFG_ROWS = 1'b0;

  typedef struct packed {
    logic            sweep_en;
    logic            cap_in;
    logic            stk_rd;
    logic            top_ld;
    logic            nb_rd;
    logic            step_wr;
    logic            step_wr2;
    logic            cell_rd;
    logic            start_set;
    logic            res_ld;
    logic [EV_W-1:0] res_ev;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic stack_empty;
    logic nb_last;
    logic carve;
    logic out_free;
  } sts_t;

  function automatic logic [WALL_W-1:0] wall_here(input logic [DIR_W-1:0] dir);
    logic [WALL_W-1:0] w;
    case (dir)
      DIR_LEFT:  w = WALL_LEFT;
      DIR_RIGHT: w = WALL_RIGHT;
      DIR_DOWN:  w = WALL_DOWN;
      default:   w = WALL_UP;
    endcase
    return w;
  endfunction

  function automatic logic [WALL_W-1:0] wall_there(input logic [DIR_W-1:0] dir);
    logic [WALL_W-1:0] w;
    case (dir)
      DIR_LEFT:  w = WALL_RIGHT;
      DIR_RIGHT: w = WALL_LEFT;
      DIR_DOWN:  w = WALL_UP;
      default:   w = WALL_DOWN;
    endcase
    return w;
  endfunction

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/mbg_ram.sv
// generic single write port ram with registered read
`default_nettype none

module mbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/mbg_ctrl.sv
// sequencing state machine of the maze backtracker generator
`default_nettype none

module mbg_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_valid_i,
  input  wire logic [mbg_pkg::FUNC_W-1:0] s_func_i,
  output logic                            s_ready_o,
  input  wire mbg_pkg::sts_t              sts_i,
  output mbg_pkg::cmd_t                   cmd_o
);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SWEEP = 4'd2;
  localparam logic [3:0] ST_STK   = 4'd3;
  localparam logic [3:0] ST_TOP   = 4'd4;
  localparam logic [3:0] ST_NB    = 4'd5;
  localparam logic [3:0] ST_WAIT  = 4'd6;
  localparam logic [3:0] ST_DEC   = 4'd7;
  localparam logic [3:0] ST_WR2   = 4'd8;
  localparam logic [3:0] ST_RDC   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0]                   state_q, state_d;
  logic [mbg_pkg::EV_W-1:0]     ev_q, ev_d;
  logic                         accept;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i & s_ready_o;

  always_comb begin
    state_d = state_q;
    ev_d    = ev_q;
    cmd_o   = '0;
    cmd_o.res_ev = ev_q;
    case (state_q)
      ST_CLR: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap_in = 1'b1;
          case (s_func_i)
            mbg_pkg::FN_START: state_d = ST_SWEEP;
            mbg_pkg::FN_STEP:  state_d = ST_STK;
            default:           state_d = ST_RDC;
          endcase
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.start_set = 1'b1;
          ev_d    = mbg_pkg::EV_START;
          state_d = ST_FIN;
        end
      end
      ST_STK: begin
        if (sts_i.stack_empty) begin
          ev_d    = mbg_pkg::EV_IDLE;
          state_d = ST_FIN;
        end else begin
          cmd_o.stk_rd = 1'b1;
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        cmd_o.top_ld = 1'b1;
        state_d = ST_NB;
      end
      ST_NB: begin
        cmd_o.nb_rd = 1'b1;
        if (sts_i.nb_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.step_wr = 1'b1;
        if (sts_i.carve) begin
          ev_d    = mbg_pkg::EV_CARVED;
          state_d = ST_WR2;
        end else begin
          ev_d    = mbg_pkg::EV_BACK;
          state_d = ST_FIN;
        end
      end
      ST_WR2: begin
        cmd_o.step_wr2 = 1'b1;
        state_d = ST_FIN;
      end
      ST_RDC: begin
        cmd_o.cell_rd = 1'b1;
        ev_d    = mbg_pkg::EV_READ;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      ev_q    <= mbg_pkg::EV_IDLE;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
    end
  end

endmodule

`default_nettype wire

### design/mbg_datapath.sv
// maps, cell stack, neighbour selection and result register
`default_nettype none

module mbg_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [0:0]                     cfg_addr_i,
  input  wire logic [mbg_pkg::DIM_W-1:0]      cfg_wdata_i,
  input  wire logic [mbg_pkg::DRAW_W-1:0]     draw_i,
  input  wire logic [mbg_pkg::ROW_W-1:0]      read_row_i,
  input  wire logic [mbg_pkg::COL_W-1:0]      read_col_i,
  input  wire mbg_pkg::cmd_t                  cmd_i,
  output mbg_pkg::sts_t                       sts_o,
  input  wire logic                           m_ready_i,
  output logic                                m_valid_o,
  output logic [mbg_pkg::EV_W-1:0]            m_user_o,
  output logic [mbg_pkg::OUT_DATA_W-1:0]      m_data_o
);

  localparam int CW = mbg_pkg::CELL_W;
  localparam int RW = mbg_pkg::ROW_W;
  localparam int KW = mbg_pkg::COL_W;
  localparam int DW = mbg_pkg::DIM_W;

  logic [DW-1:0]               rows_q, cols_q;
  logic [CW-1:0]               sweep_q;
  logic [mbg_pkg::CNT_W-1:0]   cnt_q;
  logic [mbg_pkg::DRAW_W-1:0]  draw_q;
  logic [RW-1:0]               rr_q, top_r_q;
  logic [KW-1:0]               rc_q, top_c_q;
  logic [mbg_pkg::NB_W-1:0]    nb_k_q, pend_k_q;
  logic                        pend_q;
  logic [mbg_pkg::WALL_W-1:0]  own_walls_q;
  logic [3:0]                  vis_q;
  logic [mbg_pkg::DIR_W-1:0]   dir_q;
  logic [CW-1:0]               nxt_q;

  logic                        out_vld_q;
  logic [mbg_pkg::EV_W-1:0]    out_ev_q;
  logic [RW-1:0]               out_row_q;
  logic [KW-1:0]               out_col_q;
  logic [mbg_pkg::DIR_W-1:0]   out_dir_q;
  logic [mbg_pkg::WALL_W-1:0]  out_walls_q;
  logic                        out_fin_q;

  logic [DW-1:0]               nr, nc;
  logic [RW-1:0]               r_m1, r_p1;
  logic [KW-1:0]               c_m1, c_p1;
  logic                        row_in, col_in;
  logic [3:0]                  ingrid, cand;
  logic [2:0]                  n_cand;
  logic [1:0]                  k_sel, seen;
  logic                        found;
  logic [mbg_pkg::DIR_W-1:0]   sel_dir;
  logic [CW-1:0]               nb_addr, nxt, cnt_m1;
  logic                        carve, stack_room;

  logic                        map_we, map_re, stk_we;
  logic [CW-1:0]               map_waddr, map_raddr, stk_waddr, stk_wdata;
  logic [mbg_pkg::MAP_W-1:0]   map_wdata, map_rdata;
  logic [CW-1:0]               stk_rdata;

  // neighbour geometry around the stack top
  assign nr   = mbg_pkg::eff_dim(rows_q, mbg_pkg::ROWS_MAX);
  assign nc   = mbg_pkg::eff_dim(cols_q, mbg_pkg::COLS_MAX);
  assign r_m1 = top_r_q - RW'(1);
  assign r_p1 = top_r_q + RW'(1);
  assign c_m1 = top_c_q - KW'(1);
  assign c_p1 = top_c_q + KW'(1);

  // a stack top outside the live grid only sees neighbours inside it
  assign row_in    = (DW'(top_r_q) < nr);
  assign col_in    = (DW'(top_c_q) < nc);
  assign ingrid[0] = (top_c_q != '0) && (DW'(c_m1) < nc) && row_in;
  assign ingrid[1] = ((DW'(top_c_q) + DW'(1)) < nc) && row_in;
  assign ingrid[2] = (top_r_q != '0) && (DW'(r_m1) < nr) && col_in;
  assign ingrid[3] = ((DW'(top_r_q) + DW'(1)) < nr) && col_in;
  assign cand      = ingrid & ~vis_q;
  assign n_cand    = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
  assign carve     = (cand != '0);

  // draw mod count
  always_comb begin
    case (n_cand)
      3'd1:    k_sel = 2'd0;
      3'd2:    k_sel = {1'b0, draw_q[0]};
      3'd3:    k_sel = (draw_q == 2'd3) ? 2'd0 : draw_q;
      default: k_sel = draw_q;
    endcase
  end

  always_comb begin
    seen    = '0;
    found   = 1'b0;
    sel_dir = mbg_pkg::DIR_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] && !found) begin
        if (seen == k_sel) begin
          sel_dir = mbg_pkg::DIR_W'(i);
          found   = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    case (sel_dir)
      mbg_pkg::DIR_LEFT:  nxt = {top_r_q, c_m1};
      mbg_pkg::DIR_RIGHT: nxt = {top_r_q, c_p1};
      mbg_pkg::DIR_DOWN:  nxt = {r_m1, top_c_q};
      default:            nxt = {r_p1, top_c_q};
    endcase
  end

  always_comb begin
    case (nb_k_q)
      3'd0:    nb_addr = {top_r_q, top_c_q};
      3'd1:    nb_addr = {top_r_q, c_m1};
      3'd2:    nb_addr = {top_r_q, c_p1};
      3'd3:    nb_addr = {r_m1, top_c_q};
      default: nb_addr = {r_p1, top_c_q};
    endcase
  end

  // wall and visited map
  assign map_we = cmd_i.sweep_en | (cmd_i.step_wr & carve) | cmd_i.step_wr2;

  always_comb begin
    if (cmd_i.sweep_en) begin
      map_waddr = sweep_q;
      map_wdata = {(sweep_q == '0), mbg_pkg::WALLS_ALL};
    end else if (cmd_i.step_wr) begin
      map_waddr = {top_r_q, top_c_q};
      map_wdata = {1'b1, own_walls_q & ~mbg_pkg::wall_here(sel_dir)};
    end else begin
      map_waddr = nxt_q;
      map_wdata = {1'b1, mbg_pkg::WALLS_ALL & ~mbg_pkg::wall_there(dir_q)};
    end
  end

  assign map_re    = cmd_i.nb_rd | cmd_i.cell_rd;
  assign map_raddr = cmd_i.cell_rd ? {rr_q, rc_q} : nb_addr;

  mbg_ram #(
    .WIDTH (mbg_pkg::MAP_W),
    .DEPTH (mbg_pkg::CELLS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // cell stack
  assign stack_room = (cnt_q < mbg_pkg::CNT_W'(mbg_pkg::CELLS));
  assign cnt_m1     = CW'(cnt_q - mbg_pkg::CNT_W'(1));
  assign stk_we     = (cmd_i.sweep_en & (sweep_q == '0)) |
                      (cmd_i.step_wr & carve & stack_room);
  assign stk_waddr  = cmd_i.sweep_en ? '0 : cnt_q[CW-1:0];
  assign stk_wdata  = cmd_i.sweep_en ? '0 : nxt;

  mbg_ram #(
    .WIDTH (CW),
    .DEPTH (mbg_pkg::CELLS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.stk_rd),
    .raddr_i (cnt_m1),
    .rdata_o (stk_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= mbg_pkg::ROWS_MAX;
      cols_q    <= mbg_pkg::COLS_MAX;
      sweep_q   <= '0;
      cnt_q     <= '0;
      nb_k_q    <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == mbg_pkg::CFG_ROWS) begin
          rows_q <= cfg_wdata_i;
        end else begin
          cols_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.sweep_en) begin
        sweep_q <= sweep_q + CW'(1);
      end
      if (cmd_i.start_set) begin
        cnt_q <= mbg_pkg::CNT_W'(1);
      end else if (cmd_i.step_wr) begin
        if (!carve) begin
          cnt_q <= cnt_q - mbg_pkg::CNT_W'(1);
        end else if (stack_room) begin
          cnt_q <= cnt_q + mbg_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.top_ld) begin
        nb_k_q <= '0;
      end else if (cmd_i.nb_rd) begin
        nb_k_q <= nb_k_q + mbg_pkg::NB_W'(1);
      end
      pend_q <= cmd_i.nb_rd;
      if (cmd_i.res_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      draw_q <= draw_i;
      rr_q   <= read_row_i;
      rc_q   <= read_col_i;
    end
    if (cmd_i.top_ld) begin
      {top_r_q, top_c_q} <= stk_rdata;
    end
    pend_k_q <= nb_k_q;
    if (pend_q) begin
      case (pend_k_q)
        mbg_pkg::NB_OWN: own_walls_q <= map_rdata[mbg_pkg::WALL_W-1:0];
        3'd1:            vis_q[0]    <= map_rdata[mbg_pkg::WALL_W];
        3'd2:            vis_q[1]    <= map_rdata[mbg_pkg::WALL_W];
        3'd3:            vis_q[2]    <= map_rdata[mbg_pkg::WALL_W];
        default:         vis_q[3]    <= map_rdata[mbg_pkg::WALL_W];
      endcase
    end
    if (cmd_i.step_wr) begin
      dir_q <= sel_dir;
      nxt_q <= nxt;
    end
    if (cmd_i.res_ld) begin
      out_ev_q  <= cmd_i.res_ev;
      out_fin_q <= (cnt_q == '0);
      case (cmd_i.res_ev)
        mbg_pkg::EV_CARVED, mbg_pkg::EV_BACK: begin
          out_row_q <= top_r_q;
          out_col_q <= top_c_q;
        end
        mbg_pkg::EV_READ: begin
          out_row_q <= rr_q;
          out_col_q <= rc_q;
        end
        default: begin
          out_row_q <= '0;
          out_col_q <= '0;
        end
      endcase
      out_dir_q   <= (cmd_i.res_ev == mbg_pkg::EV_CARVED) ? dir_q : mbg_pkg::DIR_LEFT;
      out_walls_q <= (cmd_i.res_ev == mbg_pkg::EV_READ) ?
                     map_rdata[mbg_pkg::WALL_W-1:0] : '0;
    end
  end

  assign sts_o.sweep_last  = (sweep_q == {CW{1'b1}});
  assign sts_o.stack_empty = (cnt_q == '0);
  assign sts_o.nb_last     = (nb_k_q == mbg_pkg::NB_LAST);
  assign sts_o.carve       = carve;
  assign sts_o.out_free    = ~out_vld_q | m_ready_i;

  assign m_valid_o = out_vld_q;
  assign m_user_o  = out_ev_q;
  assign m_data_o  = {7'd0, out_fin_q, out_walls_q, out_dir_q, out_col_q, out_row_q};

endmodule

`default_nettype wire

### design/maze_backtracker_generator_top.sv
// top level of the maze backtracker generator
// after reset a clearing pass runs over the maps before the first item is taken
// start: one map sweep between accept and result; read: one map read
// step: five map reads per step, through the single read port of the map
// a step on an empty stack returns the idle event; one item in flight, next item taken on the cycle after
// the result register loads; config registers reset to 32 rows and 32 columns
`default_nettype none

module maze_backtracker_generator_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [0:0]                         cfg_addr_i,
  input  wire logic [mbg_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // rand_draw[1:0], read_row[6:2], read_col[11:7], zero fill
  input  wire logic [mbg_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // func[1:0]
  input  wire logic [mbg_pkg::FUNC_W-1:0]         s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // cell_row[4:0], cell_col[9:5], direction[11:10], walls[15:12], finished[16], zero fill
  output logic [mbg_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  // event_res[2:0]
  output logic [mbg_pkg::EV_W-1:0]                m_axis_tuser_o
);

  mbg_pkg::cmd_t cmd;
  mbg_pkg::sts_t sts;

  mbg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_func_i  (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mbg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .draw_i      (s_axis_tdata_i[1:0]),
    .read_row_i  (s_axis_tdata_i[6:2]),
    .read_col_i  (s_axis_tdata_i[11:7]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_user_o    (m_axis_tuser_o),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
